// ===== rtl/rapqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rapqt_pkg
// Shared widths and constants of the range-add point-query segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rapqt_pkg;

  localparam int unsigned MaxLeaves = 1024;
  localparam int unsigned NodeCount = 4096;
  localparam int unsigned WalkDepth = 24;

  localparam int unsigned PosW   = $clog2(MaxLeaves);
  localparam int unsigned SizeW  = PosW + 1;
  localparam int unsigned NodeW  = $clog2(NodeCount);
  localparam int unsigned CountW = $clog2(WalkDepth + 1);
  localparam int unsigned ValW   = 64;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(MaxLeaves);

  localparam logic ReqAdd   = 1'b0;
  localparam logic ReqQuery = 1'b1;

  localparam logic StatusDone   = 1'b0;
  localparam logic StatusReject = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/rapqt_if.sv =====
// ----------------------------------------------------------------------------
// rapqt_if
// Valid/ready channels of the tree: request, response and size register.
// ----------------------------------------------------------------------------
`default_nettype none

interface rapqt_req_if;
  import rapqt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [PosW-1:0]        left_index;
  logic [PosW-1:0]        right_index;
  logic signed [ValW-1:0] add_value;

  modport source (output valid, req_type, left_index, right_index, add_value,
                  input ready);
  modport sink   (input valid, req_type, left_index, right_index, add_value,
                  output ready);
endinterface

interface rapqt_rsp_if;
  import rapqt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic signed [ValW-1:0] point_value;

  modport source (output valid, status, point_value, input ready);
  modport sink   (input valid, status, point_value, output ready);
endinterface

interface rapqt_cfg_if;
  import rapqt_pkg::*;
  logic             valid;
  logic             ready;
  logic [SizeW-1:0] size_in_use;

  modport source (output valid, size_in_use, input ready);
  modport sink   (input valid, size_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/rapqt_ram.sv =====
// ----------------------------------------------------------------------------
// rapqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rapqt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/range_add_point_query_tree.sv =====
// From request transfer to result valid: a range add pops one stack entry per visited
// node and writes back each covering node; a point query reads one node per tree level,
// root to leaf; a rejected item goes straight to its result.
// One item at a time: the next request is taken the cycle after the result is loaded,
// once any earlier result has gone. After reset the node RAM is cleared, one entry per
// cycle, all 4096 entries, with the request channel held not ready.
// ----------------------------------------------------------------------------
// range_add_point_query_tree
// Segment tree with 64-bit range add and point query over a node RAM,
// walked by an explicit stack for updates and a root-to-leaf read for queries.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_point_query_tree
  import rapqt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rapqt_cfg_if.sink  cfg_i,
  rapqt_req_if.sink  req_i,
  rapqt_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_POP, S_UPD, S_QRY, S_QLAST, S_FIN
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [PosW-1:0]  segl;
    logic [PosW-1:0]  segr;
    logic [PosW-1:0]  lo;
    logic [PosW-1:0]  hi;
  } walk_t;

  state_e state_q, state_d;

  logic [SizeW-1:0]  size_q;
  logic [NodeW-1:0]  clr_cnt_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q;
  logic              res_status_q, res_status_d;
  logic [ValW-1:0]   res_value_q;
  logic              rsp_status_q;

  walk_t             stack_q [WalkDepth];
  logic [ValW-1:0]   value_q;
  logic [ValW-1:0]   sum_q, sum_d;
  logic [NodeW-1:0]  upd_node_q;
  logic [NodeW-1:0]  q_node_q;
  logic [PosW-1:0]   q_segl_q, q_segr_q, pos_q;
  logic              q_first_q;

  // effective size and request checks
  logic [SizeW-1:0] eff_size;
  logic [PosW-1:0]  last_pos;
  logic             req_fire, req_bad;

  always_comb begin
    eff_size = size_q;
    if (size_q == '0) begin
      eff_size = SizeW'(1);
    end else if (size_q > SizeW'(MaxLeaves)) begin
      eff_size = SizeW'(MaxLeaves);
    end
  end

  assign last_pos = PosW'(eff_size - SizeW'(1));
  assign req_fire = req_i.valid && req_i.ready;
  assign req_bad  = (req_i.req_type == ReqAdd)
                  ? ((req_i.left_index > req_i.right_index) ||
                     ({1'b0, req_i.right_index} >= eff_size))
                  : ({1'b0, req_i.left_index} >= eff_size);

  // stack top and split
  logic [CountW-1:0] base;
  walk_t             top;
  logic [PosW-1:0]   mid;
  logic [SizeW-1:0]  mid_p1;
  logic              covers, push_r, push_l;
  logic [CountW-1:0] idx_l;
  walk_t             ent_r, ent_l;

  assign base   = cnt_q - CountW'(1);
  assign top    = stack_q[(cnt_q == '0) ? '0 : base];
  assign mid    = top.segl + ((top.segr - top.segl) >> 1);
  assign mid_p1 = {1'b0, mid} + SizeW'(1);
  assign covers = (top.segl == top.lo) && (top.hi == top.segr);
  assign push_r = !covers && (mid_p1 <= {1'b0, top.hi});
  assign push_l = !covers && (top.lo <= mid);
  assign idx_l  = base + CountW'(push_r);

  always_comb begin
    ent_r.node = NodeW'({top.node, 1'b0} + (NodeW + 1)'(2));
    ent_r.segl = PosW'(mid_p1);
    ent_r.segr = top.segr;
    ent_r.lo   = ({1'b0, top.lo} > mid_p1) ? top.lo : PosW'(mid_p1);
    ent_r.hi   = top.hi;
    ent_l.node = NodeW'({top.node, 1'b0} + (NodeW + 1)'(1));
    ent_l.segl = top.segl;
    ent_l.segr = mid;
    ent_l.lo   = top.lo;
    ent_l.hi   = (top.hi < mid) ? top.hi : mid;
  end

  // query step
  logic [PosW-1:0]  q_mid;
  logic             q_leaf;
  logic [NodeW-1:0] q_child_l, q_child_r;

  assign q_mid     = q_segl_q + ((q_segr_q - q_segl_q) >> 1);
  assign q_leaf    = (q_segl_q >= q_segr_q);
  assign q_child_l = NodeW'({q_node_q, 1'b0} + (NodeW + 1)'(1));
  assign q_child_r = NodeW'({q_node_q, 1'b0} + (NodeW + 1)'(2));

  // node RAM
  logic             ram_we, ram_re;
  logic [NodeW-1:0] ram_waddr, ram_raddr;
  logic [ValW-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = upd_node_q;
    ram_wdata = ram_rdata + value_q;
    ram_re    = 1'b0;
    ram_raddr = top.node;
    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      S_POP: ram_re = (cnt_q != '0) && covers;
      S_UPD: ram_we = 1'b1;
      S_QRY: begin
        ram_re    = 1'b1;
        ram_raddr = q_node_q;
      end
      default: ;
    endcase
  end

  rapqt_ram #(
    .Width (ValW),
    .Depth (NodeCount)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    sum_d        = sum_q;
    unique case (state_q)
      S_CLR: begin
        if (clr_cnt_q == NodeW'(NodeCount - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          sum_d = '0;
          if (req_bad) begin
            res_status_d = StatusReject;
            state_d      = S_FIN;
          end else begin
            res_status_d = StatusDone;
            if (req_i.req_type == ReqAdd) begin
              cnt_d   = CountW'(1);
              state_d = S_POP;
            end else begin
              state_d = S_QRY;
            end
          end
        end
      end
      S_POP: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else if (covers) begin
          cnt_d   = base;
          state_d = S_UPD;
        end else begin
          cnt_d = base;
          if (push_r && (base < CountW'(WalkDepth))) begin
            cnt_d = base + CountW'(1);
          end
          if (push_l && (idx_l < CountW'(WalkDepth))) begin
            cnt_d = idx_l + CountW'(1);
          end
        end
      end
      S_UPD: state_d = S_POP;
      S_QRY: begin
        sum_d = q_first_q ? sum_q : sum_q + ram_rdata;
        if (q_leaf) begin
          state_d = S_QLAST;
        end
      end
      S_QLAST: begin
        sum_d   = sum_q + ram_rdata;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      size_q       <= SizeReset;
      clr_cnt_q    <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= StatusDone;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      res_status_q <= res_status_d;
      if (cfg_i.valid) begin
        size_q <= cfg_i.size_in_use;
      end
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + NodeW'(1);
      end
      if (state_q == S_FIN && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (state_q == S_IDLE && req_fire) begin
      value_q   <= req_i.add_value;
      pos_q     <= req_i.left_index;
      q_node_q  <= '0;
      q_segl_q  <= '0;
      q_segr_q  <= last_pos;
      q_first_q <= 1'b1;
      stack_q[0] <= '{node: '0, segl: '0, segr: last_pos,
                      lo: req_i.left_index, hi: req_i.right_index};
    end
    if (state_q == S_POP && cnt_q != '0) begin
      upd_node_q <= top.node;
      if (push_r && (base < CountW'(WalkDepth))) begin
        stack_q[base[CountW-1:0]] <= ent_r;
      end
      if (push_l && (idx_l < CountW'(WalkDepth))) begin
        stack_q[idx_l] <= ent_l;
      end
    end
    if (state_q == S_QRY) begin
      q_first_q <= 1'b0;
      if (!q_leaf) begin
        if (pos_q <= q_mid) begin
          q_node_q <= q_child_l;
          q_segr_q <= q_mid;
        end else begin
          q_node_q <= q_child_r;
          q_segl_q <= PosW'({1'b0, q_mid} + SizeW'(1));
        end
      end
    end
    if (state_q == S_FIN && (!out_valid_q || rsp_o.ready)) begin
      res_value_q  <= (res_status_q == StatusReject) ? '0 : sum_q;
      rsp_status_q <= res_status_q;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.point_value = res_value_q;

  // checks
  a_clr_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !req_i.ready)
    else $error("request taken during RAM clear");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(WalkDepth))
    else $error("walk stack count beyond depth");

  a_upd_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_POP))
    else $error("write-back not followed by stack pop");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("idle straight after a request transfer");

endmodule

`default_nettype wire
